FILE: rtl/weighted_round_robin_server_pick_macros.svh
// Assertion macros for the server pick block.
`ifndef WEIGHTED_ROUND_ROBIN_SERVER_PICK_MACROS_SVH
`define WEIGHTED_ROUND_ROBIN_SERVER_PICK_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define WRR_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define WRR_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

FILE: rtl/wrr_pkg.sv
// Shared types and codes for the server pick block.
`timescale 1ns / 1ps
`default_nettype none
package wrr_pkg;
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_BAD  = 2'd1;
	localparam logic [1:0] OP_PICK = 2'd2;

	localparam logic [1:0] CLS_NORMAL = 2'd0;
	localparam logic [1:0] CLS_ALWAYS = 2'd1;
	localparam logic [1:0] CLS_LAST   = 2'd2;
	localparam logic [1:0] CLS_BAD    = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_NONE  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_REFILL,
		S_PSCAN,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input word, clear scan results
		logic scan_clr;  // restart index at zero (match / class scan, refill sweep)
		logic scan_step; // examine current index, advance
		logic refill_step; // reload credit at current index
		logic pscan_clr; // start credit scan at position
		logic pscan_step;
		logic commit;    // apply op effects and form result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;  // current index is last slot
		logic pscan_last; // pick scan is at the last slot of its sweep
		logic pscan_hit;  // pick scan found a credited server
		logic need_refill;
		logic is_pick;
		logic no_usable;
		logic has_always;
	} sts_t;
endpackage
`default_nettype wire

FILE: rtl/wrr_ctrl.sv
// Sequencer for add, mark-bad and pick operations.
`timescale 1ns / 1ps
`default_nettype none
module wrr_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire            out_stall,
	input  wrr_pkg::sts_t  sts,
	output wrr_pkg::cmd_t  cmd
);
	wrr_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wrr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wrr_pkg::S_IDLE: begin
				if (in_valid) state_d = wrr_pkg::S_SCAN;
			end
			wrr_pkg::S_SCAN: begin
				if (sts.scan_last) state_d = wrr_pkg::S_DECIDE;
			end
			wrr_pkg::S_DECIDE: begin
				if (!sts.is_pick || sts.no_usable || sts.has_always)
					state_d = wrr_pkg::S_DONE;
				else if (sts.need_refill)
					state_d = wrr_pkg::S_REFILL;
				else
					state_d = wrr_pkg::S_PSCAN;
			end
			wrr_pkg::S_REFILL: begin
				if (sts.scan_last) state_d = wrr_pkg::S_PSCAN;
			end
			wrr_pkg::S_PSCAN: begin
				if (sts.pscan_hit || sts.pscan_last) state_d = wrr_pkg::S_DONE;
			end
			wrr_pkg::S_DONE: begin
				if (!out_stall) state_d = wrr_pkg::S_IDLE;
			end
			default: state_d = wrr_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			wrr_pkg::S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
				cmd.scan_clr = in_valid;
			end
			wrr_pkg::S_SCAN: cmd.scan_step = 1'b1;
			wrr_pkg::S_DECIDE: begin
				cmd.scan_clr = 1'b1;
				cmd.pscan_clr = !sts.need_refill;
				cmd.commit = !sts.is_pick || sts.no_usable || sts.has_always;
			end
			wrr_pkg::S_REFILL: begin
				cmd.refill_step = 1'b1;
				cmd.pscan_clr = sts.scan_last;
			end
			wrr_pkg::S_PSCAN: begin
				cmd.pscan_step = 1'b1;
				cmd.commit = sts.pscan_hit || sts.pscan_last;
			end
			wrr_pkg::S_DONE: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/wrr_dp.sv
// Server table, scan index, credit logic and result registers.
`timescale 1ns / 1ps
`default_nettype none
module wrr_dp #(
	parameter int MAX_SERVERS = 16,
	parameter int WEIGHT_BITS = 8
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wrr_pkg::cmd_t      cmd,
	output wrr_pkg::sts_t      sts,
	input  wire  [1:0]         op,
	input  wire  [31:0]        ip_addr,
	input  wire  [15:0]        port,
	input  wire  [1:0]         weight_kind,
	input  wire  [7:0]         weight,
	output logic [1:0]         status,
	output logic [3:0]         sel_index,
	output logic [31:0]        sel_ip,
	output logic [15:0]        sel_port,
	output logic [4:0]         usable_count,
	output logic [4:0]         bad_count
);
	localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CW = $clog2(MAX_SERVERS + 1);
	localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SERVERS - 1);

	// table
	logic [31:0]            addr_q   [MAX_SERVERS];
	logic [15:0]            port_q   [MAX_SERVERS];
	logic [1:0]             cls_q    [MAX_SERVERS];
	logic [WEIGHT_BITS-1:0] wgt_q    [MAX_SERVERS];
	logic [WEIGHT_BITS-1:0] cred_q   [MAX_SERVERS];
	logic [MAX_SERVERS-1:0] valid_q, usable_q;
	logic [IW-1:0]          pos_q;
	logic                   round_q;
	logic [CW-1:0]          total_q, usable_n_q;

	// captured word and scan results
	logic [1:0]             op_q, kind_q;
	logic [31:0]            ip_q;
	logic [15:0]            port_in_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [IW-1:0]          idx_q, pcnt_q;
	logic                   match_q, always_q, credit_q;
	logic [IW-1:0]          match_idx_q, always_idx_q, last_idx_q;
	logic                   last_q;

	logic [WEIGHT_BITS-1:0] w_sat;
	always_comb begin
		if (WEIGHT_BITS >= 8) w_sat = WEIGHT_BITS'(weight);
		else if (weight > 8'(WMAX)) w_sat = WMAX;
		else w_sat = weight[WEIGHT_BITS-1:0];
	end

	// per-index views
	logic is_usable, is_normal_cred, hit;
	assign is_usable = usable_q[idx_q];
	assign is_normal_cred = usable_q[idx_q] && cls_q[idx_q] == wrr_pkg::CLS_NORMAL
		&& cred_q[idx_q] != '0;
	assign hit = valid_q[idx_q] && addr_q[idx_q] == ip_q && port_q[idx_q] == port_in_q;

	// pick scan index: position plus count, wrapping
	logic [IW:0]   psum;
	logic [IW-1:0] pidx;
	always_comb begin
		psum = {1'b0, pos_q} + {1'b0, pcnt_q};
		if (psum >= (IW+1)'(MAX_SERVERS)) psum = psum - (IW+1)'(MAX_SERVERS);
		pidx = psum[IW-1:0];
	end
	logic p_ok;
	assign p_ok = usable_q[pidx] && cls_q[pidx] == wrr_pkg::CLS_NORMAL && cred_q[pidx] != '0;

	// credits left after spending one at pidx: any other credited slot, or pidx keeps some
	logic [WEIGHT_BITS-1:0] cred_dec;
	assign cred_dec = cred_q[pidx] - 1'b1;

	// any normal credited server other than pidx (small OR over flags)
	logic others_cred;
	always_comb begin
		others_cred = 1'b0;
		for (int i = 0; i < MAX_SERVERS; i++)
			if (IW'(i) != pidx && usable_q[i] && cls_q[i] == wrr_pkg::CLS_NORMAL
				&& cred_q[i] != '0) others_cred = 1'b1;
	end

	assign sts.scan_last   = idx_q == LAST_IDX;
	assign sts.pscan_last  = pcnt_q == LAST_IDX;
	assign sts.pscan_hit   = p_ok;
	assign sts.need_refill = round_q || !credit_q;
	assign sts.is_pick     = op_q == wrr_pkg::OP_PICK;
	assign sts.no_usable   = usable_n_q == '0;
	assign sts.has_always  = always_q;

	logic [WEIGHT_BITS:0] wsum, csum;
	assign wsum = {1'b0, wgt_q[match_idx_q]} + {1'b0, w_q};
	assign csum = {1'b0, cred_q[match_idx_q]} + {1'b0, w_q};

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			usable_q <= '0;
			pos_q <= '0;
			round_q <= 1'b1;
			total_q <= '0;
			usable_n_q <= '0;
			idx_q <= '0;
			pcnt_q <= '0;
			match_q <= 1'b0;
			always_q <= 1'b0;
			credit_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				match_q <= 1'b0;
				always_q <= 1'b0;
				credit_q <= 1'b0;
				last_q <= 1'b0;
			end
			if (cmd.scan_clr) idx_q <= '0;
			if (cmd.scan_step) begin
				if (hit && !match_q) match_q <= 1'b1;
				if (is_usable && cls_q[idx_q] == wrr_pkg::CLS_ALWAYS && !always_q)
					always_q <= 1'b1;
				if (is_usable && cls_q[idx_q] == wrr_pkg::CLS_LAST && !last_q)
					last_q <= 1'b1;
				if (is_normal_cred) credit_q <= 1'b1;
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.refill_step) begin
				idx_q <= idx_q + 1'b1;
				if (sts.scan_last) begin
					pos_q <= '0;
					round_q <= 1'b0;
				end
			end
			if (cmd.pscan_clr) pcnt_q <= '0;
			if (cmd.pscan_step && !p_ok) pcnt_q <= pcnt_q + 1'b1;
			// commit
			if (cmd.commit) begin
				unique case (op_q)
					wrr_pkg::OP_ADD: begin
						if (total_q < CW'(MAX_SERVERS) && !match_q) begin
							valid_q[total_q[IW-1:0]] <= 1'b1;
							usable_q[total_q[IW-1:0]] <= kind_q != wrr_pkg::CLS_BAD;
							total_q <= total_q + 1'b1;
							if (kind_q != wrr_pkg::CLS_BAD) usable_n_q <= usable_n_q + 1'b1;
						end
					end
					wrr_pkg::OP_BAD: begin
						if (match_q && usable_q[match_idx_q]) begin
							usable_q[match_idx_q] <= 1'b0;
							usable_n_q <= usable_n_q - 1'b1;
						end
					end
					wrr_pkg::OP_PICK: begin
						if (p_ok && cmd.pscan_step) begin
							pos_q <= (cred_dec != '0) ? pidx
								: ((pidx == LAST_IDX) ? '0 : pidx + 1'b1);
							if (cred_dec == '0 && !others_cred) round_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// captured word, match slot indexes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			ip_q <= ip_addr;
			port_in_q <= port;
			kind_q <= weight_kind;
			w_q <= w_sat;
		end
		if (cmd.scan_step) begin
			if (hit && !match_q) match_idx_q <= idx_q;
			if (is_usable && cls_q[idx_q] == wrr_pkg::CLS_ALWAYS && !always_q)
				always_idx_q <= idx_q;
			if (is_usable && cls_q[idx_q] == wrr_pkg::CLS_LAST && !last_q)
				last_idx_q <= idx_q;
		end
	end

	// table payload
	always_ff @(posedge clk) begin
		if (cmd.refill_step && usable_q[idx_q]) cred_q[idx_q] <= wgt_q[idx_q];
		if (cmd.commit) begin
			unique case (op_q)
				wrr_pkg::OP_ADD: begin
					if (total_q < CW'(MAX_SERVERS)) begin
						if (!match_q) begin
							addr_q[total_q[IW-1:0]] <= ip_q;
							port_q[total_q[IW-1:0]] <= port_in_q;
							cls_q[total_q[IW-1:0]] <= kind_q;
							wgt_q[total_q[IW-1:0]] <= w_q;
							cred_q[total_q[IW-1:0]] <= w_q;
						end else if (usable_q[match_idx_q] && kind_q != wrr_pkg::CLS_BAD) begin
							if (cls_q[match_idx_q] == wrr_pkg::CLS_LAST
								|| kind_q == wrr_pkg::CLS_LAST)
								cls_q[match_idx_q] <= wrr_pkg::CLS_LAST;
							else if (cls_q[match_idx_q] == wrr_pkg::CLS_ALWAYS
								|| kind_q == wrr_pkg::CLS_ALWAYS)
								cls_q[match_idx_q] <= wrr_pkg::CLS_ALWAYS;
							else begin
								wgt_q[match_idx_q] <= wsum[WEIGHT_BITS] ? WMAX
									: wsum[WEIGHT_BITS-1:0];
								cred_q[match_idx_q] <= csum[WEIGHT_BITS] ? WMAX
									: csum[WEIGHT_BITS-1:0];
							end
						end
					end
				end
				wrr_pkg::OP_BAD: begin
					if (match_q && usable_q[match_idx_q]) cls_q[match_idx_q] <= wrr_pkg::CLS_BAD;
				end
				wrr_pkg::OP_PICK: begin
					if (p_ok && cmd.pscan_step) cred_q[pidx] <= cred_dec;
				end
				default: ;
			endcase
		end
	end

	// result word
	logic [CW-1:0] un_next;
	always_comb begin
		un_next = usable_n_q;
		if (op_q == wrr_pkg::OP_ADD && total_q < CW'(MAX_SERVERS) && !match_q
			&& kind_q != wrr_pkg::CLS_BAD) un_next = usable_n_q + 1'b1;
		if (op_q == wrr_pkg::OP_BAD && match_q && usable_q[match_idx_q])
			un_next = usable_n_q - 1'b1;
	end
	logic [CW-1:0] tot_next;
	assign tot_next = (op_q == wrr_pkg::OP_ADD && total_q < CW'(MAX_SERVERS) && !match_q)
		? total_q + 1'b1 : total_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status <= wrr_pkg::ST_OK;
			sel_index <= '0;
			sel_ip <= '0;
			sel_port <= '0;
			usable_count <= 5'(un_next);
			bad_count <= 5'(tot_next - un_next);
			if (op_q == wrr_pkg::OP_ADD && total_q >= CW'(MAX_SERVERS)) status <= wrr_pkg::ST_FULL;
			if (op_q == wrr_pkg::OP_PICK) begin
				if (usable_n_q == '0) status <= wrr_pkg::ST_NONE;
				else if (always_q) begin
					sel_index <= 4'(always_idx_q);
					sel_ip <= addr_q[always_idx_q];
					sel_port <= port_q[always_idx_q];
				end else if (cmd.pscan_step && p_ok) begin
					sel_index <= 4'(pidx);
					sel_ip <= addr_q[pidx];
					sel_port <= port_q[pidx];
				end else if (usable_n_q == CW'(1) && last_q) begin
					sel_index <= 4'(last_idx_q);
					sel_ip <= addr_q[last_idx_q];
					sel_port <= port_q[last_idx_q];
				end else status <= wrr_pkg::ST_NONE;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/weighted_round_robin_server_pick.sv
// Top level of the weighted round-robin server pick block.
// Usage:
//  - Input channel (in_valid/in_stall) takes one word: op, ip_addr, port,
//    weight_kind, weight. Output channel (out_valid/out_stall) gives one
//    result word per input word: status, selection and counts.
//  - One word is handled at a time. Each word runs a table scan over all
//    MAX_SERVERS slots (match, always-use, last-resort, credit flags),
//    then a decide step, and for a pick with usable servers and no
//    always-use server an optional refill sweep over all slots plus a
//    credit scan of up to MAX_SERVERS slots from the saved position.
//  - The result shows once the scan and decide steps end for add and
//    mark-bad, and after the credit scan for a pick that runs it; a new
//    word is taken the cycle after the result is taken.
//  - Reset empties the table and forces a refill on the first pick.
//  - While the receiver stalls, the result holds and no input is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_round_robin_server_pick_macros.svh"
module weighted_round_robin_server_pick #(
	parameter int MAX_SERVERS = 16,
	parameter int WEIGHT_BITS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  op,
	input  wire  [31:0] ip_addr,
	input  wire  [15:0] port,
	input  wire  [1:0]  weight_kind,
	input  wire  [7:0]  weight,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  status,
	output logic [3:0]  sel_index,
	output logic [31:0] sel_ip,
	output logic [15:0] sel_port,
	output logic [4:0]  usable_count,
	output logic [4:0]  bad_count
);
	wrr_pkg::cmd_t cmd;
	wrr_pkg::sts_t sts;

	wrr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	wrr_dp #(.MAX_SERVERS(MAX_SERVERS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.op(op), .ip_addr(ip_addr), .port(port), .weight_kind(weight_kind),
		.weight(weight), .status(status), .sel_index(sel_index), .sel_ip(sel_ip),
		.sel_port(sel_port), .usable_count(usable_count), .bad_count(bad_count)
	);

	// no word taken while a result waits
	`WRR_ASSERT_IMP(a_no_accept_busy, clk, arst_n, out_valid, in_stall)
	// a commit is followed by a shown result
	`WRR_ASSERT_NEXT(a_commit_out, clk, arst_n, cmd.commit, out_valid)
	// a stalled result holds its status
	`WRR_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, $stable(status))
endmodule
`default_nettype wire
